FILE: hw/rtl/wdvs_pkg.sv
// ----------------------------------------------------------------------------
// Water dispense valve sequencer package
// Shared types and constants for the valve sequencer: transfer payloads,
// item modes, valve phase codes and register indexes.
// ----------------------------------------------------------------------------
`default_nettype none

package wdvs_pkg;

  localparam int COUNT_BITS_DEF = 16;
  localparam int CFG_INDEX_BITS = 4;
  localparam int CFG_DATA_BITS  = 16;
  localparam int USAGE_BITS     = 20;
  localparam logic [USAGE_BITS-1:0] USAGE_MAX = 20'hFFFFF;
  localparam logic [15:0] SHOWN_MAX = 16'hFFFF;

  typedef enum logic [1:0] {
    MODE_TICK  = 2'd0,
    MODE_PULSE = 2'd1,
    MODE_START = 2'd2,
    MODE_STOP  = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    PH_START = 2'd0,
    PH_WAIT  = 2'd1,
    PH_HOLD  = 2'd2
  } phase_t;

  localparam logic [CFG_INDEX_BITS-1:0] CFG_PULSES_PER_10ML      = 4'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_PADDING_PULSES       = 4'd1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_WAIT_TICKS           = 4'd2;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_RATE_LATCH_THRESHOLD = 4'd3;

  typedef struct packed {
    mode_t       mode;
    logic [15:0] target_pulses;
    logic        error_active;
  } in_t;

  typedef struct packed {
    logic                  status;
    logic                  air_valve_open;
    logic                  inlet_valve_open;
    logic                  outlet_valve_open;
    logic [15:0]           dispensed_pulses;
    logic                  outage_start;
    logic                  outage_stop;
    logic                  rate_latch;
    logic                  usage_valid;
    logic [USAGE_BITS-1:0] usage_ml;
    logic                  end_sound;
  } out_t;

endpackage

`default_nettype wire

FILE: hw/rtl/water_dispense_valve_sequencer_top.sv
// ----------------------------------------------------------------------------
// Water dispense valve sequencer
// Drives the air, inlet and outlet valves of a metered dispense from ticks,
// flow pulses, start and stop items, and reports usage at close.
// ----------------------------------------------------------------------------
// One item is taken at a time and gives one result. Most items pass through
// the result register and then the output register. The tick that starts
// the close sequence with a nonzero pulses_per_10ml also passes through the
// serial restoring divider, which forms the usage quotient one bit per cycle,
// and then the scaling state. A result waiting in the output register does
// not stop the next item from entering.
// Configuration writes are taken in any cycle and must come only while idle.
`default_nettype none

module water_dispense_valve_sequencer_top #(
  parameter int COUNT_BITS = wdvs_pkg::COUNT_BITS_DEF
) (
  input  wire                                 clk,
  input  wire                                 rst,
  input  wire                                 in_valid,
  output logic                                in_ready,
  input  wdvs_pkg::in_t                       in_data,
  output logic                                out_valid,
  input  wire                                 out_ready,
  output wdvs_pkg::out_t                      out_data,
  input  wire                                 cfg_valid,
  output logic                                cfg_ready,
  input  wire [wdvs_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  wire [wdvs_pkg::CFG_DATA_BITS-1:0]   cfg_data
);
  import wdvs_pkg::*;

  localparam int WB = (COUNT_BITS > 16) ? COUNT_BITS : 16;
  localparam int PW = (COUNT_BITS + 4 > USAGE_BITS) ? COUNT_BITS + 4 : USAGE_BITS;
  localparam int BCW = $clog2(COUNT_BITS + 1);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_DIV   = 4'b0010,
    S_SCALE = 4'b0100,
    S_DONE  = 4'b1000
  } state_t;

  state_t state;

  logic [15:0] pulses_per_10ml;
  logic [7:0]  padding_pulses;
  logic [7:0]  wait_ticks;
  logic [15:0] rate_latch_threshold;

  logic                  dispense_request;
  logic [15:0]           target_count;
  phase_t                open_phase;
  phase_t                close_phase;
  logic [7:0]            wait_count;
  logic [7:0]            padding_count;
  logic [COUNT_BITS-1:0] pulse_count;
  logic                  counting_enabled;
  logic                  air_open;
  logic                  inlet_open;
  logic                  outlet_open;

  logic                  dispense_request_next;
  logic [15:0]           target_count_next;
  phase_t                open_phase_next;
  phase_t                close_phase_next;
  logic [7:0]            wait_count_next;
  logic [7:0]            padding_count_next;
  logic [COUNT_BITS-1:0] pulse_count_next;
  logic                  counting_enabled_next;
  logic                  air_open_next;
  logic                  inlet_open_next;
  logic                  outlet_open_next;

  out_t                  res;
  out_t                  res_next;
  logic                  div_go;
  logic                  report;
  logic [COUNT_BITS-1:0] shown;

  logic [COUNT_BITS-1:0] dvd;
  logic [15:0]           rem;
  logic [BCW-1:0]        bit_cnt;
  logic [16:0]           rem_sh;
  logic                  rem_ge;
  logic [PW-1:0]         prod;

  logic in_xfer;

  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign in_xfer   = in_valid && in_ready;

  always_comb begin
    dispense_request_next = dispense_request;
    target_count_next     = target_count;
    open_phase_next       = open_phase;
    close_phase_next      = close_phase;
    wait_count_next       = wait_count;
    padding_count_next    = padding_count;
    pulse_count_next      = pulse_count;
    counting_enabled_next = counting_enabled;
    air_open_next         = air_open;
    inlet_open_next       = inlet_open;
    outlet_open_next      = outlet_open;
    res_next              = '0;
    div_go                = 1'b0;
    report                = 1'b0;

    unique case (in_data.mode)
      MODE_TICK: begin
        if (dispense_request &&
            (in_data.error_active ||
             (WB'(target_count) <= WB'(pulse_count)))) begin
          dispense_request_next = 1'b0;
          res_next.end_sound    = 1'b1;
          res_next.status       = 1'b1;
        end else if (dispense_request) begin
          close_phase_next = PH_START;
          case (open_phase)
            PH_START: begin
              air_open_next      = 1'b0;
              inlet_open_next    = 1'b1;
              padding_count_next = padding_pulses;
              wait_count_next    = wait_ticks;
              open_phase_next    = PH_WAIT;
            end
            PH_WAIT: begin
              if (wait_count != 8'd0) begin
                wait_count_next = wait_count - 8'd1;
              end else begin
                pulse_count_next      = '0;
                counting_enabled_next = 1'b1;
                res_next.outage_start = 1'b1;
                outlet_open_next      = 1'b1;
                open_phase_next       = PH_HOLD;
              end
            end
            PH_HOLD: begin
              inlet_open_next  = 1'b1;
              outlet_open_next = 1'b1;
              air_open_next    = 1'b0;
            end
            default: begin
            end
          endcase
        end else begin
          open_phase_next = PH_START;
          case (close_phase)
            PH_START: begin
              outlet_open_next      = 1'b0;
              air_open_next         = 1'b1;
              res_next.rate_latch   = (WB'(pulse_count) > WB'(rate_latch_threshold));
              report                = 1'b1;
              res_next.usage_valid  = 1'b1;
              div_go                = (pulses_per_10ml != 16'd0);
              pulse_count_next      = '0;
              counting_enabled_next = 1'b0;
              res_next.outage_stop  = 1'b1;
              wait_count_next       = wait_ticks;
              close_phase_next      = PH_WAIT;
            end
            PH_WAIT: begin
              if (wait_count != 8'd0) begin
                wait_count_next = wait_count - 8'd1;
              end else begin
                air_open_next    = 1'b1;
                inlet_open_next  = 1'b0;
                outlet_open_next = 1'b0;
                close_phase_next = PH_HOLD;
              end
            end
            default: begin
            end
          endcase
        end
      end
      MODE_PULSE: begin
        if (counting_enabled) begin
          if (padding_count == 8'd0) begin
            if (pulse_count != '1) begin
              pulse_count_next = pulse_count + COUNT_BITS'(1);
            end
          end else begin
            padding_count_next = padding_count - 8'd1;
          end
        end
      end
      MODE_START: begin
        dispense_request_next = 1'b1;
        target_count_next     = in_data.target_pulses;
      end
      MODE_STOP: begin
        dispense_request_next = 1'b0;
      end
      default: begin
      end
    endcase

    shown = report ? pulse_count : pulse_count_next;
    res_next.dispensed_pulses = (WB'(shown) > WB'(SHOWN_MAX)) ? SHOWN_MAX : 16'(shown);
    res_next.air_valve_open    = air_open_next;
    res_next.inlet_valve_open  = inlet_open_next;
    res_next.outlet_valve_open = outlet_open_next;
  end

  assign rem_sh = {rem, dvd[COUNT_BITS-1]};
  assign rem_ge = (rem_sh >= {1'b0, pulses_per_10ml});
  assign prod   = (PW'(dvd) << 3) + (PW'(dvd) << 1);

  always_ff @(posedge clk) begin
    if (rst) begin
      pulses_per_10ml      <= 16'd0;
      padding_pulses       <= 8'd10;
      wait_ticks           <= 8'd10;
      rate_latch_threshold <= 16'd50;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_PULSES_PER_10ML:      pulses_per_10ml      <= cfg_data;
        CFG_PADDING_PULSES:       padding_pulses       <= cfg_data[7:0];
        CFG_WAIT_TICKS:           wait_ticks           <= cfg_data[7:0];
        CFG_RATE_LATCH_THRESHOLD: rate_latch_threshold <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dispense_request <= 1'b0;
      target_count     <= 16'd0;
      open_phase       <= PH_START;
      close_phase      <= PH_START;
      wait_count       <= 8'd0;
      padding_count    <= 8'd0;
      pulse_count      <= '0;
      counting_enabled <= 1'b0;
      air_open         <= 1'b0;
      inlet_open       <= 1'b0;
      outlet_open      <= 1'b0;
    end else if (in_xfer) begin
      dispense_request <= dispense_request_next;
      target_count     <= target_count_next;
      open_phase       <= open_phase_next;
      close_phase      <= close_phase_next;
      wait_count       <= wait_count_next;
      padding_count    <= padding_count_next;
      pulse_count      <= pulse_count_next;
      counting_enabled <= counting_enabled_next;
      air_open         <= air_open_next;
      inlet_open       <= inlet_open_next;
      outlet_open      <= outlet_open_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      bit_cnt   <= '0;
    end else begin
      if (state == S_DONE && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_xfer) begin
            res     <= res_next;
            dvd     <= pulse_count;
            rem     <= 16'd0;
            bit_cnt <= BCW'(COUNT_BITS);
            state   <= div_go ? S_DIV : S_DONE;
          end
        end
        S_DIV: begin
          rem     <= rem_ge ? 16'(rem_sh - {1'b0, pulses_per_10ml}) : rem_sh[15:0];
          dvd     <= {dvd[COUNT_BITS-2:0], rem_ge};
          bit_cnt <= bit_cnt - BCW'(1);
          if (bit_cnt == BCW'(1)) begin
            state <= S_SCALE;
          end
        end
        S_SCALE: begin
          res.usage_ml <= (prod > PW'(USAGE_MAX)) ? USAGE_MAX : prod[USAGE_BITS-1:0];
          state        <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            out_data <= res;
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_outlet_needs_inlet: assert property (@(posedge clk) disable iff (rst)
    outlet_open |-> (inlet_open && !air_open))
    else $error("Outlet valve open without inlet open and air closed.");

  a_plain_item_skips_div: assert property (@(posedge clk) disable iff (rst)
    (in_xfer && !div_go) |=> (state == S_DONE))
    else $error("Item without a usage division did not go straight to output.");

  a_div_to_scale: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV && bit_cnt == BCW'(1)) |=> (state == S_SCALE))
    else $error("Divider did not hand over to scaling after the last bit.");

  a_done_loads_out: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && (!out_valid || out_ready)) |=> (out_valid && state == S_IDLE))
    else $error("Finished result was not moved to the output register.");

  a_usage_only_reported: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.usage_ml != '0) |-> out_data.usage_valid)
    else $error("Nonzero usage on a result without a usage report.");

endmodule

`default_nettype wire
